[src/mft_pkg.sv]
package mft_pkg;

    localparam int TOTAL_BITS_DEF = 40;

    localparam logic [10:0] TARGET_ID_RST        = 11'd517;
    localparam logic        FRAME_LAYOUT_RST     = 1'b0;
    localparam logic [16:0] ENCODER_RANGE_RST    = 17'd8192;
    localparam logic [31:0] DEGREES_PER_TICK_RST = 32'd188743680;

    localparam logic [47:0] ANGLE_MAX_MAG = 48'h8000_0000_0000;
    localparam logic [64:0] ROUND_HALF    = 65'h8000;

    localparam logic LAYOUT_BIG    = 1'b0;
    localparam logic LAYOUT_LITTLE = 1'b1;

    typedef enum logic [1:0] {
        CFG_TARGET_ID        = 2'd0,
        CFG_FRAME_LAYOUT     = 2'd1,
        CFG_ENCODER_RANGE    = 2'd2,
        CFG_DEGREES_PER_TICK = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } t_frame;

    typedef struct packed {
        logic [7:0]         temperature;
        logic [15:0]        encoder_count;
        logic signed [15:0] speed;
        logic signed [15:0] torque_current;
        logic [7:0]         command_echo;
        logic signed [47:0] total_angle;
    } t_result;

endpackage

[src/mft_scale.sv]
module mft_scale #(
    parameter int TOTAL_BITS = mft_pkg::TOTAL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic signed [TOTAL_BITS-1:0] i_tick,
    input  logic [31:0]                  i_dpt,
    output logic signed [47:0]           o_angle
);

    localparam int HI_W  = (TOTAL_BITS > 32) ? TOTAL_BITS - 32 : 1;
    localparam int EXT_W = 32 + HI_W;

    logic [TOTAL_BITS-1:0] tick_u;
    logic [TOTAL_BITS-1:0] mag;
    logic [EXT_W-1:0]      mag_ext;
    logic [HI_W-1:0]       mag_hi;
    logic [31:0]           mag_lo;

    logic [HI_W+31:0] r_hi;
    logic [63:0]      r_lo;
    logic             r_neg;

    logic             hi_over;
    logic [64:0]      lo_rnd;
    logic [49:0]      q_sum;
    logic [47:0]      q_mag;

    assign tick_u  = i_tick;
    assign mag     = i_tick[TOTAL_BITS-1] ? (~tick_u + 1'b1) : tick_u;
    assign mag_ext = EXT_W'(mag);
    assign mag_hi  = mag_ext[EXT_W-1:32];
    assign mag_lo  = mag_ext[31:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hi  <= mag_hi * i_dpt;
            r_lo  <= mag_lo * i_dpt;
            r_neg <= i_tick[TOTAL_BITS-1];
        end
    end

    always_comb begin
        hi_over = (r_hi[HI_W+31:32] != '0);
        lo_rnd  = {1'b0, r_lo} + mft_pkg::ROUND_HALF;
        q_sum   = {2'b00, r_hi[31:0], 16'h0000} + 50'(lo_rnd[64:16]);
        if (hi_over || (q_sum > 50'(mft_pkg::ANGLE_MAX_MAG))) begin
            q_mag = mft_pkg::ANGLE_MAX_MAG;
        end else begin
            q_mag = q_sum[47:0];
        end
        if (r_neg) begin
            o_angle = $signed(48'h0 - q_mag);
        end else if (q_mag > mft_pkg::ANGLE_MAX_MAG - 48'd1) begin
            o_angle = $signed(mft_pkg::ANGLE_MAX_MAG - 48'd1);
        end else begin
            o_angle = $signed(q_mag);
        end
    end

endmodule

[src/motor_feedback_angle_tracker.sv]
// An accepted frame passes through r_s1, r_s2, r_s3 and r_out before its result beat on o_valid.
// Throughput: one frame per cycle while i_stall does not hold the pipeline; the tick total updates
// once per frame and the angle scaling spans two stages: multiply, then round and saturate.
// Frames whose identifier differs are dropped at the input register.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the
// unwrap state and loads the register defaults.
module motor_feedback_angle_tracker #(
    parameter int TOTAL_BITS = mft_pkg::TOTAL_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mft_pkg::t_frame  i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output mft_pkg::t_result o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

    localparam int SUM_W = TOTAL_BITS + 1;

    localparam logic signed [TOTAL_BITS-1:0] TICK_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic signed [TOTAL_BITS-1:0] TICK_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

    logic [10:0] r_target_id;
    logic        r_layout;
    logic [16:0] r_range;
    logic [31:0] r_dpt;

    logic                         r_seen_first;
    logic [15:0]                  r_prev;
    logic signed [TOTAL_BITS-1:0] r_tick;
    logic signed [TOTAL_BITS-1:0] n_tick;

    logic             r_s1_valid;
    mft_pkg::t_frame  r_s1;
    logic             r_s2_valid;
    mft_pkg::t_result r_s2;
    logic signed [TOTAL_BITS-1:0] r_s2_tick;
    logic             r_s3_valid;
    mft_pkg::t_result r_s3;
    logic             r_out_valid;
    mft_pkg::t_result r_out;
    mft_pkg::t_result n_out;

    logic ready_o, ready3, ready2, ready1;
    logic adv1, adv2, adv3, accept;

    mft_pkg::t_result dec;
    logic signed [16:0]      direct;
    logic signed [18:0]      direct_w;
    logic signed [18:0]      range_w;
    logic signed [18:0]      wrapped;
    logic [18:0]             abs_d;
    logic [18:0]             abs_w;
    logic signed [18:0]      delta;
    logic signed [SUM_W-1:0] sum;
    logic signed [47:0]      angle;

    assign ready_o = !r_out_valid || !i_stall;
    assign ready3  = !r_s3_valid || ready_o;
    assign ready2  = !r_s2_valid || ready3;
    assign ready1  = !r_s1_valid || ready2;
    assign adv3    = r_s3_valid && ready_o;
    assign adv2    = r_s2_valid && ready3;
    assign adv1    = r_s1_valid && ready2;
    assign o_stall = !ready1;
    assign accept  = i_valid && ready1;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= mft_pkg::TARGET_ID_RST;
            r_layout    <= mft_pkg::FRAME_LAYOUT_RST;
            r_range     <= mft_pkg::ENCODER_RANGE_RST;
            r_dpt       <= mft_pkg::DEGREES_PER_TICK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mft_pkg::CFG_TARGET_ID:        r_target_id <= i_cfg_data[10:0];
                mft_pkg::CFG_FRAME_LAYOUT:     r_layout    <= i_cfg_data[0];
                mft_pkg::CFG_ENCODER_RANGE:    r_range     <= i_cfg_data[16:0];
                mft_pkg::CFG_DEGREES_PER_TICK: r_dpt       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        dec = '0;
        if (r_layout == mft_pkg::LAYOUT_LITTLE) begin
            dec.command_echo   = r_s1.byte0;
            dec.temperature    = r_s1.byte1;
            dec.torque_current = $signed({r_s1.byte3, r_s1.byte2});
            dec.speed          = $signed({r_s1.byte5, r_s1.byte4});
            dec.encoder_count  = {r_s1.byte7, r_s1.byte6};
        end else begin
            dec.temperature    = r_s1.byte6;
            dec.encoder_count  = {r_s1.byte0, r_s1.byte1};
            dec.speed          = $signed({r_s1.byte2, r_s1.byte3});
            dec.torque_current = $signed({r_s1.byte4, r_s1.byte5});
        end
    end

    always_comb begin
        direct   = $signed({1'b0, dec.encoder_count}) - $signed({1'b0, r_prev});
        direct_w = 19'(direct);
        range_w  = 19'($signed({1'b0, r_range}));
        if (direct < 0) begin
            wrapped = direct_w + range_w;
        end else if (direct > 0) begin
            wrapped = direct_w - range_w;
        end else begin
            wrapped = '0;
        end
        abs_d = (direct_w < 0) ? 19'(-direct_w) : 19'(direct_w);
        abs_w = (wrapped < 0) ? 19'(-wrapped) : 19'(wrapped);
        delta = (abs_w > abs_d) ? direct_w : wrapped;
        sum   = SUM_W'(r_tick) + SUM_W'(delta);
        if (!r_seen_first) begin
            n_tick = '0;
        end else if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            n_tick = sum[SUM_W-1] ? TICK_MIN : TICK_MAX;
        end else begin
            n_tick = sum[TOTAL_BITS-1:0];
        end
    end

    always_comb begin
        n_out             = r_s3;
        n_out.total_angle = angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first <= 1'b0;
            r_prev       <= '0;
            r_tick       <= '0;
        end else if (adv1) begin
            r_seen_first <= 1'b1;
            r_prev       <= dec.encoder_count;
            r_tick       <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r_s1_valid <= i_valid && (i_data.frame_id == r_target_id);
            end
            if (ready2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ready3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (ready_o) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_data;
        end
        if (adv1) begin
            r_s2      <= dec;
            r_s2_tick <= n_tick;
        end
        if (adv2) begin
            r_s3 <= r_s2;
        end
        if (adv3) begin
            r_out <= n_out;
        end
    end

    mft_scale #(
        .TOTAL_BITS(TOTAL_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_load  (adv2),
        .i_tick  (r_s2_tick),
        .i_dpt   (r_dpt),
        .o_angle (angle)
    );

    a_seen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_first |=> r_seen_first)
        else $error("first-frame flag dropped without reset");

    a_s2_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> r_seen_first)
        else $error("decoded beat present before any frame captured");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && r_s3_valid && r_s2_valid && r_s1_valid))
        else $error("input stalled while pipeline has room");

endmodule

[tb/motor_feedback_angle_tracker_test.sv]
module motor_feedback_angle_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_LIMIT = 2000;
    localparam int          RAMP_LOOPS = 20;
    localparam logic [16:0] RAMP_RANGE = 17'd131069;
    localparam int          PHASE_HITS = 150;

    class angle_tracker_scoreboard;
        logic [10:0]      target_id;
        logic             layout;
        logic [16:0]      enc_range;
        logic [31:0]      deg_per_tick;
        bit               seen_first;
        logic [15:0]      prev_count;
        longint           tick_total;
        mft_pkg::t_result expected_q[$];
        int               errors;

        function new();
            target_id    = mft_pkg::TARGET_ID_RST;
            layout       = mft_pkg::FRAME_LAYOUT_RST;
            enc_range    = mft_pkg::ENCODER_RANGE_RST;
            deg_per_tick = mft_pkg::DEGREES_PER_TICK_RST;
            seen_first   = 1'b0;
            prev_count   = '0;
            tick_total   = 0;
            errors       = 0;
        endfunction

        function void set_register(mft_pkg::t_cfg_idx idx, logic [31:0] value);
            case (idx)
                mft_pkg::CFG_TARGET_ID:        target_id = value[10:0];
                mft_pkg::CFG_FRAME_LAYOUT:     layout = value[0];
                mft_pkg::CFG_ENCODER_RANGE:    enc_range = value[16:0];
                mft_pkg::CFG_DEGREES_PER_TICK: deg_per_tick = value;
                default: ;
            endcase
        endfunction

        function logic [47:0] angle_of(longint ticks);
            logic [63:0] mag;
            logic [63:0] hi_part;
            logic [63:0] q;
            logic [63:0] top;
            bit          neg;
            top = {16'd0, mft_pkg::ANGLE_MAX_MAG};
            neg = ticks < 0;
            mag = neg ? -ticks : ticks;
            hi_part = {32'd0, mag[63:32]} * {32'd0, deg_per_tick};
            if (hi_part >= 64'h1_0000_0000) begin
                q = top;
            end else begin
                q = (hi_part << 16)
                    + (({32'd0, mag[31:0]} * {32'd0, deg_per_tick} + 64'h8000) >> 16);
                if (q > top) begin
                    q = top;
                end
            end
            if (neg) begin
                q = -q;
            end else if (q > top - 64'd1) begin
                q = top - 64'd1;
            end
            return q[47:0];
        endfunction

        function void note_frame(mft_pkg::t_frame f);
            mft_pkg::t_result r;
            logic [15:0]      enc;
            longint           direct;
            longint           wrapped;
            longint           step;
            longint           top;
            if (f.frame_id != target_id) begin
                return;
            end
            if (layout == mft_pkg::LAYOUT_BIG) begin
                enc              = {f.byte0, f.byte1};
                r.speed          = {f.byte2, f.byte3};
                r.torque_current = {f.byte4, f.byte5};
                r.temperature    = f.byte6;
                r.command_echo   = '0;
            end else begin
                r.command_echo   = f.byte0;
                r.temperature    = f.byte1;
                r.torque_current = {f.byte3, f.byte2};
                r.speed          = {f.byte5, f.byte4};
                enc              = {f.byte7, f.byte6};
            end
            r.encoder_count = enc;
            if (!seen_first) begin
                seen_first = 1'b1;
                tick_total = 0;
            end else begin
                direct  = longint'(enc) - longint'(prev_count);
                wrapped = 0;
                if (direct < 0) begin
                    wrapped = direct + longint'(enc_range);
                end else if (direct > 0) begin
                    wrapped = direct - longint'(enc_range);
                end
                // half a turn goes to the wrapped delta
                step = (((wrapped < 0) ? -wrapped : wrapped) > ((direct < 0) ? -direct : direct))
                       ? direct : wrapped;
                top = (longint'(1) <<< (mft_pkg::TOTAL_BITS_DEF - 1)) - 1;
                if (step > 0 && tick_total > top - step) begin
                    tick_total = top;
                end else if (step < 0 && tick_total < -top - 1 - step) begin
                    tick_total = -top - 1;
                end else begin
                    tick_total += step;
                end
            end
            prev_count    = enc;
            r.total_angle = angle_of(tick_total);
            expected_q.push_back(r);
        endfunction

        function void check_result(mft_pkg::t_result got);
            mft_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.temperature !== want.temperature) begin
                $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
                errors++;
            end
            if (got.encoder_count !== want.encoder_count) begin
                $error("encoder_count: expected %0d, got %0d",
                       want.encoder_count, got.encoder_count);
                errors++;
            end
            if (got.speed !== want.speed) begin
                $error("speed: expected %0d, got %0d", want.speed, got.speed);
                errors++;
            end
            if (got.torque_current !== want.torque_current) begin
                $error("torque_current: expected %0d, got %0d",
                       want.torque_current, got.torque_current);
                errors++;
            end
            if (got.command_echo !== want.command_echo) begin
                $error("command_echo: expected %0d, got %0d",
                       want.command_echo, got.command_echo);
                errors++;
            end
            if (got.total_angle !== want.total_angle) begin
                $error("total_angle: expected %0d, got %0d", want.total_angle, got.total_angle);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    mft_pkg::t_frame  i_data = '0;
    logic             i_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [1:0]       i_cfg_index = '0;
    logic [31:0]      i_cfg_data = '0;
    logic             o_stall;
    logic             o_valid;
    logic             o_cfg_ready;
    mft_pkg::t_result o_data;

    angle_tracker_scoreboard sb;
    bit                      no_idle = 1'b0;
    int                      idle_cycles = 0;

    motor_feedback_angle_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic mft_pkg::t_frame pack_frame(logic [10:0] id, logic [15:0] enc,
                                                   logic [15:0] spd, logic [15:0] cur,
                                                   logic [7:0] temp, logic [7:0] cmd);
        mft_pkg::t_frame f;
        f.frame_id = id;
        if (sb.layout == mft_pkg::LAYOUT_BIG) begin
            {f.byte0, f.byte1} = enc;
            {f.byte2, f.byte3} = spd;
            {f.byte4, f.byte5} = cur;
            f.byte6 = temp;
            f.byte7 = cmd;
        end else begin
            f.byte0 = cmd;
            f.byte1 = temp;
            {f.byte3, f.byte2} = cur;
            {f.byte5, f.byte4} = spd;
            {f.byte7, f.byte6} = enc;
        end
        return f;
    endfunction

    function automatic mft_pkg::t_frame random_frame();
        logic [15:0]     enc;
        logic [15:0]     half;
        mft_pkg::t_frame f;
        half = sb.enc_range[16:1];
        case ($urandom_range(0, 5))
            0: enc = 16'($urandom());
            1: enc = sb.prev_count + 16'($urandom_range(0, 128)) - 16'd64;
            2: enc = sb.prev_count + half;
            3: enc = sb.prev_count - half;
            4: enc = (sb.enc_range == 0) ? 16'($urandom())
                                         : 16'($urandom_range(0, sb.enc_range - 1));
            default: enc = sb.prev_count;
        endcase
        f = pack_frame(sb.target_id, enc, 16'($urandom()), 16'($urandom()),
                       8'($urandom()), 8'($urandom()));
        if ($urandom_range(0, 9) < 2) begin
            f.frame_id = $urandom_range(0, 1) ? 11'($urandom())
                                              : sb.target_id ^ (11'd1 << $urandom_range(0, 10));
        end
        return f;
    endfunction

    task automatic push_frame(mft_pkg::t_frame f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= f;
        do @(negedge i_clk); while (o_stall !== 1'b0);
        sb.note_frame(f);
        @(posedge i_clk);
    endtask

    task automatic write_reg(mft_pkg::t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(logic [10:0] tid, logic lay, logic [16:0] rng, logic [31:0] dpt);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(mft_pkg::CFG_TARGET_ID, {junk[31:11], tid});
        write_reg(mft_pkg::CFG_FRAME_LAYOUT, {junk[31:1], lay});
        write_reg(mft_pkg::CFG_ENCODER_RANGE, {junk[31:17], rng});
        write_reg(mft_pkg::CFG_DEGREES_PER_TICK, dpt);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the sender until every result is back, then let dropped frames clear
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic wind_angle(int loops, bit rising);
        logic [15:0] pos [3];
        if (rising) begin
            pos = '{16'h7FFF, 16'hFFFF, 16'h0000};
        end else begin
            pos = '{16'hFFFF, 16'h7FFF, 16'h0000};
        end
        for (int i = 0; i < loops; i++) begin
            for (int k = 0; k < 3; k++) begin
                push_frame(pack_frame(sb.target_id, pos[k], 16'($urandom()), 16'($urandom()),
                                      8'($urandom()), 8'($urandom())));
            end
        end
    endtask

    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 5);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(negedge i_clk); while (o_valid !== 1'b1);
            @(posedge i_clk);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall == 1'b0) begin
                sb.check_result(o_data);
            end
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        int              hits;
        mft_pkg::t_frame f;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: big-endian layout, 8192 counts per turn
        push_frame(pack_frame(11'd0, 16'h1234, 16'h5678, 16'h9ABC, 8'h11, 8'h22));
        push_frame(pack_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'd4096, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'd0, 16'h8000, 16'h7FFF, 8'h80, 8'h01));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'd8191, 16'hFFFF, 16'h0001, 8'h7F, 8'hFE));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'd0, 16'h0001, 16'hFFFF, 8'h01, 8'h80));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'hFFFF, 16'h5555, 16'hAAAA, 8'h55, 8'hAA));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'hFFFF, 16'hAAAA, 16'h5555, 8'hAA, 8'h55));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'd100, 16'h0000, 16'h0000, 8'h00, 8'h00));
        push_frame(pack_frame(mft_pkg::TARGET_ID_RST, 16'd4196, 16'h1234, 16'h4321, 8'h42, 8'h24));

        settle();
        configure(11'h7FF, mft_pkg::LAYOUT_LITTLE, 17'd65536, 32'hFFFF_FFFF);
        push_frame(pack_frame(11'h3FF, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        push_frame(pack_frame(11'h7FF, 16'h0000, 16'h8000, 16'h7FFF, 8'h00, 8'hFF));
        push_frame(pack_frame(11'h7FF, 16'h8000, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
        push_frame(pack_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        push_frame(pack_frame(11'h7FF, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        push_frame(pack_frame(11'h7FF, 16'h8000, 16'hA5A5, 16'h5A5A, 8'hA5, 8'h5A));

        settle();
        configure(11'd0, mft_pkg::LAYOUT_BIG, 17'd2, 32'd0);
        push_frame(pack_frame(11'd0, 16'd1, 16'h0000, 16'hFFFF, 8'h00, 8'hFF));
        push_frame(pack_frame(11'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 8'h00));
        push_frame(pack_frame(11'd1, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        push_frame(pack_frame(11'd0, 16'd3, 16'h0000, 16'h0000, 8'h00, 8'h00));

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: configure(11'($urandom()), mft_pkg::LAYOUT_BIG, 17'd0, $urandom());
                1: configure(11'($urandom()), mft_pkg::LAYOUT_LITTLE, 17'd1, $urandom());
                2: configure(11'($urandom()), 1'($urandom()), 17'h1FFFF, 32'hFFFF_FFFF);
                3: configure(11'd0, mft_pkg::LAYOUT_LITTLE, 17'd65536, 32'd1);
                default: configure(11'($urandom()), 1'($urandom()),
                                   17'($urandom_range(2, 65536)), $urandom());
            endcase
            no_idle = 1'b0;
            hits = 0;
            while (hits < PHASE_HITS) begin
                if ($urandom_range(0, 49) == 0) begin
                    no_idle = ~no_idle;
                end
                if ($urandom_range(0, 99) == 0) begin
                    settle();
                end
                f = random_frame();
                if (f.frame_id == sb.target_id) begin
                    hits++;
                end
                push_frame(f);
            end
        end

        // wind the total down through many turns, then back up past zero
        settle();
        configure(11'($urandom()), 1'($urandom()), RAMP_RANGE, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        wind_angle(RAMP_LOOPS, 1'b0);
        wind_angle(2 * RAMP_LOOPS, 1'b1);

        no_idle = 1'b0;
        settle();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
